// ----- design/xcfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfp_pkg
// Shared types and constants for the XOR-checked frame parser.
// ----------------------------------------------------------------------------
package xcfp_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_FIRST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_SECOND   = 3'd3;

    localparam logic [BYTE_W-1:0] RST_HEADER_FIRST  = 8'd170;
    localparam logic [BYTE_W-1:0] RST_HEADER_SECOND = 8'd85;
    localparam logic [BYTE_W-1:0] RST_TAIL_FIRST    = 8'd13;
    localparam logic [BYTE_W-1:0] RST_TAIL_SECOND   = 8'd10;

    typedef enum logic [1:0] {
        KIND_PAYLOAD      = 2'd0,
        KIND_GOOD         = 2'd1,
        KIND_CHECKSUM_BAD = 2'd2,
        KIND_TAIL_BAD     = 2'd3
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [BYTE_W-1:0] tail_first;
        logic [BYTE_W-1:0] tail_second;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] payload_length;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        logic              frame_end;
    } t_result;

endpackage

// ----- design/xcfp_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfp_cfg_regs
// Header and tail match registers, written through the config channel.
// ----------------------------------------------------------------------------
module xcfp_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [xcfp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [xcfp_pkg::BYTE_W-1:0]      i_cfg_data,
    output xcfp_pkg::t_cfg                   o_cfg
);
    import xcfp_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HEADER_FIRST:  n_cfg.header_first  = i_cfg_data;
                CFG_HEADER_SECOND: n_cfg.header_second = i_cfg_data;
                CFG_TAIL_FIRST:    n_cfg.tail_first    = i_cfg_data;
                CFG_TAIL_SECOND:   n_cfg.tail_second   = i_cfg_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first  <= RST_HEADER_FIRST;
            r_cfg.header_second <= RST_HEADER_SECOND;
            r_cfg.tail_first    <= RST_TAIL_FIRST;
            r_cfg.tail_second   <= RST_TAIL_SECOND;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- design/xcfp_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfp_parser
// Frame state machine: one received word per step, payload and status results.
// ----------------------------------------------------------------------------
module xcfp_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [xcfp_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic                        i_new_burst,
    input  xcfp_pkg::t_cfg              i_cfg,
    output logic                        o_res_valid,
    output xcfp_pkg::t_result           o_res
);
    import xcfp_pkg::*;

    typedef enum logic [7:0] {
        PH_HUNT    = 8'b0000_0001,
        PH_COMMAND = 8'b0000_0010,
        PH_LENGTH  = 8'b0000_0100,
        PH_PAYLOAD = 8'b0000_1000,
        PH_CHECK   = 8'b0001_0000,
        PH_TAIL1   = 8'b0010_0000,
        PH_TAIL2   = 8'b0100_0000,
        PH_DONE    = 8'b1000_0000
    } t_phase;

    t_phase            r_phase, n_phase, e_phase;
    logic              r_saw_hf, n_saw_hf, e_saw_hf;
    logic [BYTE_W-1:0] r_cmd, n_cmd, e_cmd;
    logic [BYTE_W-1:0] r_len, n_len, e_len;
    logic [BYTE_W-1:0] r_cnt, n_cnt, e_cnt;
    logic [BYTE_W-1:0] r_xor, n_xor, e_xor;
    logic [BYTE_W-1:0] r_chk, n_chk, e_chk;
    logic              r_t1_ok, n_t1_ok, e_t1_ok;
    logic [BYTE_W-1:0] cnt_inc;

    // drop any partial frame on a new burst
    always_comb begin
        if (i_new_burst) begin
            e_phase  = PH_HUNT;
            e_saw_hf = 1'b0;
            e_cmd    = '0;
            e_len    = '0;
            e_cnt    = '0;
            e_xor    = '0;
            e_chk    = '0;
            e_t1_ok  = 1'b0;
        end else begin
            e_phase  = r_phase;
            e_saw_hf = r_saw_hf;
            e_cmd    = r_cmd;
            e_len    = r_len;
            e_cnt    = r_cnt;
            e_xor    = r_xor;
            e_chk    = r_chk;
            e_t1_ok  = r_t1_ok;
        end
    end

    assign cnt_inc = e_cnt + BYTE_W'(1);

    always_comb begin
        n_phase  = e_phase;
        n_saw_hf = e_saw_hf;
        n_cmd    = e_cmd;
        n_len    = e_len;
        n_cnt    = e_cnt;
        n_xor    = e_xor;
        n_chk    = e_chk;
        n_t1_ok  = e_t1_ok;

        o_res_valid          = 1'b0;
        o_res.kind           = KIND_PAYLOAD;
        o_res.command        = e_cmd;
        o_res.payload_length = e_len;
        o_res.payload_byte   = '0;
        o_res.payload_index  = '0;
        o_res.frame_end      = 1'b0;

        case (e_phase)
            PH_HUNT: begin
                if (e_saw_hf && (i_rx_byte == i_cfg.header_second)) begin
                    n_saw_hf = 1'b0;
                    n_phase  = PH_COMMAND;
                end else begin
                    n_saw_hf = (i_rx_byte == i_cfg.header_first);
                end
            end
            PH_COMMAND: begin
                n_cmd   = i_rx_byte;
                n_xor   = i_rx_byte;
                n_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                n_len   = i_rx_byte;
                n_xor   = e_xor ^ i_rx_byte;
                n_cnt   = '0;
                n_phase = (i_rx_byte == '0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_xor = e_xor ^ i_rx_byte;
                n_cnt = cnt_inc;
                if (cnt_inc == e_len) begin
                    n_phase = PH_CHECK;
                end
                o_res_valid         = 1'b1;
                o_res.payload_byte  = i_rx_byte;
                o_res.payload_index = e_cnt;
            end
            PH_CHECK: begin
                n_chk   = i_rx_byte;
                n_phase = PH_TAIL1;
            end
            PH_TAIL1: begin
                n_t1_ok = (i_rx_byte == i_cfg.tail_first);
                n_phase = PH_TAIL2;
            end
            PH_TAIL2: begin
                o_res_valid     = 1'b1;
                o_res.frame_end = 1'b1;
                if (!e_t1_ok || (i_rx_byte != i_cfg.tail_second)) begin
                    o_res.kind = KIND_TAIL_BAD;
                end else if (e_xor != e_chk) begin
                    o_res.kind = KIND_CHECKSUM_BAD;
                end else begin
                    o_res.kind = KIND_GOOD;
                end
                n_phase = PH_DONE;
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_saw_hf <= 1'b0;
            r_cmd    <= '0;
            r_len    <= '0;
            r_cnt    <= '0;
            r_xor    <= '0;
            r_chk    <= '0;
            r_t1_ok  <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_saw_hf <= n_saw_hf;
            r_cmd    <= n_cmd;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_xor    <= n_xor;
            r_chk    <= n_chk;
            r_t1_ok  <= n_t1_ok;
        end
    end

`ifndef SYNTHESIS
    a_status_from_tail2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.frame_end) |-> (r_phase == PH_TAIL2 && !i_new_burst))
        else $error("status result outside second tail word");

    a_done_after_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && o_res.frame_end) |=> (r_phase == PH_DONE))
        else $error("parser not done after status result");

    a_index_in_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.frame_end) |-> (o_res.payload_index < o_res.payload_length))
        else $error("payload index beyond declared length");
`endif

endmodule

// ----- design/xor_checked_frame_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checked_frame_parser
// Parses XOR-checked frames from a received byte stream.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one received word (i_rx_byte,
// i_new_burst). Output channel: o_out_valid / i_out_stall carry one result
// word (o_kind, o_command, o_payload_length, o_payload_byte, o_payload_index,
// o_frame_end). A word moves when valid is high and stall is low.
// Config channel: i_cfg_valid / o_cfg_ready write i_cfg_data to register
// i_cfg_index (header first/second, tail first/second); ready is always high.
// Write config only while the block is idle.
// An accepted input word goes into the input register, then through the parse
// logic into the result register.
// Throughput: one word per cycle while o_in_stall is low.
// Each payload word gives one result; the second tail word gives the status.
// A stalled result holds; the input register still takes one more word, then
// o_in_stall rises until the result slot frees.
// Reset clears all frame state to header hunt, empties both registers and
// loads the default header and tail values.
// ----------------------------------------------------------------------------
module xor_checked_frame_parser (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [xcfp_pkg::BYTE_W-1:0]          i_rx_byte,
    input  logic                                 i_new_burst,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [1:0]                           o_kind,
    output logic [xcfp_pkg::BYTE_W-1:0]          o_command,
    output logic [xcfp_pkg::BYTE_W-1:0]          o_payload_length,
    output logic [xcfp_pkg::BYTE_W-1:0]          o_payload_byte,
    output logic [xcfp_pkg::BYTE_W-1:0]          o_payload_index,
    output logic                                 o_frame_end,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [xcfp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [xcfp_pkg::BYTE_W-1:0]          i_cfg_data
);
    import xcfp_pkg::*;

    t_cfg              cfg;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_rx_byte;
    logic              r_new_burst;
    logic              r_out_valid;
    t_result           r_res;
    logic              out_free;
    logic              step;
    logic              in_take;
    logic              res_valid;
    t_result           res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    xcfp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    xcfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_rx_byte   (r_rx_byte),
        .i_new_burst (r_new_burst),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_rx_byte   <= i_rx_byte;
            r_new_burst <= i_new_burst;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_res <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_res.kind;
    assign o_command        = r_res.command;
    assign o_payload_length = r_res.payload_length;
    assign o_payload_byte   = r_res.payload_byte;
    assign o_payload_index  = r_res.payload_index;
    assign o_frame_end      = r_res.frame_end;

`ifndef SYNTHESIS
    a_step_drains_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !in_take) |=> !r_in_valid)
        else $error("input register not drained after parse step");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free slot");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && res_valid) |=> r_out_valid)
        else $error("parse result lost");
`endif

endmodule
